@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files that check themselves.
// Every macro samples on clk; the block's reset is rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is off while reset is high.
`define SDMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also runs through reset.
`define SDMS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/sdms_pkg.sv @@
// Package for the card mount sequencer: action, result and card-kind codes,
// register indexes, reset values and the beat structs. Depends on nothing.
package sdms_pkg;

  typedef enum logic [3:0] {
    ACT_NONE   = 4'd0,
    ACT_WAIT   = 4'd1,
    ACT_ENABLE = 4'd2,
    ACT_IDLE   = 4'd3,
    ACT_IFCOND = 4'd4,
    ACT_OP1    = 4'd5,
    ACT_OP2    = 4'd6,
    ACT_OCR    = 4'd7,
    ACT_CSD    = 4'd8,
    ACT_SETBLK = 4'd9
  } action_t;

  typedef enum logic [1:0] {
    RES_BUSY        = 2'd0,
    RES_MOUNTED     = 2'd1,
    RES_NOT_MOUNTED = 2'd2,
    RES_EN_ERR      = 2'd3
  } mount_res_t;

  typedef enum logic [2:0] {
    KIND_UNKNOWN = 3'd0,
    KIND_MMC     = 3'd1,
    KIND_SD1     = 3'd2,
    KIND_SD2     = 3'd3,
    KIND_SDHC    = 3'd4
  } card_kind_t;

  typedef enum logic [1:0] {
    REG_MAX_RESTARTS  = 2'd0,
    REG_IDLE_ATTEMPTS = 2'd1,
    REG_POWER_SETTLE  = 2'd2,
    REG_TARGET_BLOCK  = 2'd3
  } cfg_reg_t;

  localparam logic [3:0]  MaxRestartsRst  = 4'd10;
  localparam logic [3:0]  IdleAttemptsRst = 4'd10;
  localparam logic [9:0]  PowerSettleRst  = 10'd250;
  localparam logic [12:0] TargetBlockRst  = 13'd512;

  typedef struct packed {
    logic [3:0]  max_restarts;
    logic [3:0]  idle_attempts;
    logic [9:0]  power_settle_ms;
    logic [12:0] target_block_bytes;
  } sdms_cfg_t;

  typedef struct packed {
    logic        card_present;
    logic        action_ok;
    logic        response_flag;
    logic [31:0] csd_max_speed;
    logic [39:0] csd_total_bytes;
    logic [12:0] csd_block_bytes;
    logic [31:0] csd_access_time;
  } sdms_item_t;

  typedef struct packed {
    action_t     next_action;
    logic [9:0]  wait_ms;
    mount_res_t  mount_result;
    card_kind_t  card_type;
    logic [31:0] block_count;
    logic [31:0] read_access_time;
  } sdms_result_t;

endpackage

@@ rtl/sdms_if.sv @@
// Channel interfaces of the card mount sequencer: status reports in,
// action results out, register writes. Stand alone, no package needed.
interface sdms_req_if;
  logic        valid;
  logic        ready;
  logic        card_present;
  logic        action_ok;
  logic        response_flag;
  logic [31:0] csd_max_speed;
  logic [39:0] csd_total_bytes;
  logic [12:0] csd_block_bytes;
  logic [31:0] csd_access_time;

  modport source (output valid, card_present, action_ok, response_flag, csd_max_speed,
                  csd_total_bytes, csd_block_bytes, csd_access_time, input ready);
  modport sink (input valid, card_present, action_ok, response_flag, csd_max_speed,
                csd_total_bytes, csd_block_bytes, csd_access_time, output ready);
endinterface

interface sdms_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  next_action;
  logic [9:0]  wait_ms;
  logic [1:0]  mount_result;
  logic [2:0]  card_type;
  logic [31:0] block_count;
  logic [31:0] read_access_time;

  modport source (output valid, next_action, wait_ms, mount_result, card_type, block_count,
                  read_access_time, input ready);
  modport sink (input valid, next_action, wait_ms, mount_result, card_type, block_count,
                read_access_time, output ready);
endinterface

interface sdms_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/sdms_fsm.sv @@
// Mount sequencer state: phase, retry counters, card kind and held CSD values.
// One transition per step; the result is formed from the updated state. Uses sdms_pkg.
module sdms_fsm import sdms_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  sdms_item_t   item,
  input  sdms_cfg_t    cfg,
  output sdms_result_t result
);

  typedef enum logic [3:0] {
    PH_NO_CARD     = 4'd0,
    PH_SETTLE      = 4'd1,
    PH_ENABLE      = 4'd2,
    PH_IDLE        = 4'd3,
    PH_IFCOND      = 4'd4,
    PH_OP1         = 4'd5,
    PH_OP2         = 4'd6,
    PH_OCR         = 4'd7,
    PH_CSD         = 4'd8,
    PH_SETBLK      = 4'd9,
    PH_MOUNTED     = 4'd10,
    PH_NOT_MOUNTED = 4'd11,
    PH_EN_ERR      = 4'd12
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  restarts_left, restarts_left_next;
  logic [3:0]  idle_tries, idle_tries_next;
  card_kind_t  kind, kind_next;
  logic [31:0] blocks_held, blocks_held_next;
  logic [31:0] access_held, access_held_next;

  action_t     act;
  mount_res_t  res;
  logic        unusable;

  always_comb begin
    phase_next         = phase;
    restarts_left_next = restarts_left;
    idle_tries_next    = idle_tries;
    kind_next          = kind;
    blocks_held_next   = blocks_held;
    access_held_next   = access_held;
    act                = ACT_NONE;
    res                = RES_BUSY;
    unusable           = 1'b0;

    if (phase != PH_NO_CARD && !item.card_present) begin
      // card pulled: back to the no-card phase with the card kind cleared
      phase_next = PH_NO_CARD;
      kind_next  = KIND_UNKNOWN;
    end else begin
      unique case (phase)
        PH_SETTLE: begin
          phase_next = PH_ENABLE;
          act        = ACT_ENABLE;
        end
        PH_ENABLE: begin
          if (!item.action_ok) begin
            phase_next = PH_EN_ERR;
            res        = RES_EN_ERR;
          end else begin
            idle_tries_next = 4'd1;
            phase_next      = PH_IDLE;
            act             = ACT_IDLE;
          end
        end
        PH_IDLE: begin
          if (item.action_ok) begin
            phase_next = PH_IFCOND;
            act        = ACT_IFCOND;
          end else if (idle_tries < cfg.idle_attempts) begin
            idle_tries_next = idle_tries + 4'd1;
            act             = ACT_IDLE;
          end else begin
            unusable = 1'b1;
          end
        end
        PH_IFCOND: begin
          if (!item.action_ok) begin
            unusable = 1'b1;
          end else if (item.response_flag) begin
            phase_next = PH_OP2;
            act        = ACT_OP2;
          end else begin
            phase_next = PH_OP1;
            act        = ACT_OP1;
          end
        end
        PH_OP1: begin
          if (!item.action_ok) begin
            // first v1 failure tries the MMC path, a second one counts the card as unusable
            if (kind == KIND_MMC) begin
              unusable = 1'b1;
            end else begin
              kind_next       = KIND_MMC;
              idle_tries_next = 4'd1;
              phase_next      = PH_IDLE;
              act             = ACT_IDLE;
            end
          end else if (!item.response_flag) begin
            act = ACT_OP1;
          end else begin
            kind_next  = KIND_SD1;
            phase_next = PH_CSD;
            act        = ACT_CSD;
          end
        end
        PH_OP2: begin
          if (!item.action_ok) begin
            unusable = 1'b1;
          end else if (!item.response_flag) begin
            act = ACT_OP2;
          end else begin
            phase_next = PH_OCR;
            act        = ACT_OCR;
          end
        end
        PH_OCR: begin
          if (!item.action_ok) begin
            unusable = 1'b1;
          end else begin
            kind_next  = item.response_flag ? KIND_SDHC : KIND_SD2;
            phase_next = PH_CSD;
            act        = ACT_CSD;
          end
        end
        PH_CSD: begin
          if (!item.action_ok || item.csd_max_speed == '0 || item.csd_total_bytes == '0 ||
              item.csd_block_bytes == '0) begin
            unusable = 1'b1;
          end else begin
            blocks_held_next = {1'b0, item.csd_total_bytes[39:9]};
            access_held_next = item.csd_access_time;
            if (item.csd_block_bytes == cfg.target_block_bytes) begin
              phase_next = PH_MOUNTED;
              res        = RES_MOUNTED;
            end else begin
              phase_next = PH_SETBLK;
              act        = ACT_SETBLK;
            end
          end
        end
        PH_SETBLK: begin
          if (item.action_ok) begin
            phase_next = PH_MOUNTED;
            res        = RES_MOUNTED;
          end else begin
            unusable = 1'b1;
          end
        end
        PH_MOUNTED:     res = RES_MOUNTED;
        PH_NOT_MOUNTED: res = RES_NOT_MOUNTED;
        PH_EN_ERR:      res = RES_EN_ERR;
        default: begin
          // no card, and any unused phase code
          phase_next = PH_NO_CARD;
          if (item.card_present) begin
            restarts_left_next = cfg.max_restarts;
            idle_tries_next    = 4'd0;
            kind_next          = KIND_UNKNOWN;
            blocks_held_next   = '0;
            access_held_next   = '0;
            phase_next         = PH_SETTLE;
            act                = ACT_WAIT;
          end
        end
      endcase

      if (unusable) begin
        if (restarts_left != 4'd0) begin
          restarts_left_next = restarts_left - 4'd1;
          kind_next          = KIND_UNKNOWN;
          idle_tries_next    = 4'd0;
          phase_next         = PH_SETTLE;
          act                = ACT_WAIT;
        end else begin
          phase_next = PH_NOT_MOUNTED;
          res        = RES_NOT_MOUNTED;
        end
      end
    end
  end

  always_comb begin
    result.next_action      = act;
    result.wait_ms          = (act == ACT_WAIT) ? cfg.power_settle_ms : '0;
    result.mount_result     = res;
    result.card_type        = kind_next;
    result.block_count      = blocks_held_next;
    result.read_access_time = access_held_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_NO_CARD;
      restarts_left <= MaxRestartsRst;
      idle_tries    <= 4'd0;
      kind          <= KIND_UNKNOWN;
      blocks_held   <= '0;
      access_held   <= '0;
    end else if (step) begin
      phase         <= phase_next;
      restarts_left <= restarts_left_next;
      idle_tries    <= idle_tries_next;
      kind          <= kind_next;
      blocks_held   <= blocks_held_next;
      access_held   <= access_held_next;
    end
  end

endmodule

@@ rtl/sd_card_mount_sequencer.sv @@
// Channel | role        | beat
// req     | status in   | card detect, last action outcome, response flag, CSD fields
// rsp     | action out  | next action, wait, mount result, card type, blocks, access time
// cfg     | writes in   | register index, write data; always ready
//
// Each report is registered in the input register, stepped through the sequencer and
// lands in the result register; one item per cycle while rsp does not stall.
// rst is synchronous; it empties both registers and loads the register reset values.
// A stalled rsp holds its beat; req keeps flowing until the input register also fills.
// Top level of the card mount sequencer. Uses sdms_pkg, sdms_if.sv, sdms_fsm.
`include "assert_macros.svh"

module sd_card_mount_sequencer import sdms_pkg::*; (
  input logic      clk,
  input logic      rst,
  sdms_req_if.sink req,
  sdms_rsp_if.source rsp,
  sdms_cfg_if.sink cfg
);

  sdms_cfg_t    cfg_q;
  sdms_item_t   item_q;
  logic         item_valid;
  sdms_result_t fsm_result;
  sdms_result_t res_q;
  logic         res_valid;
  logic         step;

  // register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.max_restarts       <= MaxRestartsRst;
      cfg_q.idle_attempts      <= IdleAttemptsRst;
      cfg_q.power_settle_ms    <= PowerSettleRst;
      cfg_q.target_block_bytes <= TargetBlockRst;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_MAX_RESTARTS:  cfg_q.max_restarts       <= cfg.data[3:0];
        REG_IDLE_ATTEMPTS: cfg_q.idle_attempts      <= cfg.data[3:0];
        REG_POWER_SETTLE:  cfg_q.power_settle_ms    <= cfg.data[9:0];
        REG_TARGET_BLOCK:  cfg_q.target_block_bytes <= cfg.data;
        default: ;
      endcase
    end
  end

  // input register, stepped when the result register can take the result
  assign step      = item_valid && (!res_valid || rsp.ready);
  assign req.ready = !item_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      item_valid <= 1'b1;
    end else if (step) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item_q.card_present    <= req.card_present;
      item_q.action_ok       <= req.action_ok;
      item_q.response_flag   <= req.response_flag;
      item_q.csd_max_speed   <= req.csd_max_speed;
      item_q.csd_total_bytes <= req.csd_total_bytes;
      item_q.csd_block_bytes <= req.csd_block_bytes;
      item_q.csd_access_time <= req.csd_access_time;
    end
  end

  sdms_fsm u_fsm (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item_q),
    .cfg    (cfg_q),
    .result (fsm_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= fsm_result;
    end
  end

  assign rsp.valid            = res_valid;
  assign rsp.next_action      = res_q.next_action;
  assign rsp.wait_ms          = res_q.wait_ms;
  assign rsp.mount_result     = res_q.mount_result;
  assign rsp.card_type        = res_q.card_type;
  assign rsp.block_count      = res_q.block_count;
  assign rsp.read_access_time = res_q.read_access_time;

  `SDMS_ASSERT(a_no_overrun,
    (item_valid && res_valid && !rsp.ready) |-> !req.ready,
    "input register overrun while result stalled")
  `SDMS_ASSERT(a_wait_only,
    (rsp.valid && rsp.next_action != ACT_WAIT) |-> (rsp.wait_ms == 10'd0),
    "wait length shown without a wait")
  `SDMS_ASSERT(a_mounted_kind,
    (rsp.valid && rsp.mount_result == RES_MOUNTED) |->
      (rsp.card_type != KIND_UNKNOWN && rsp.next_action == ACT_NONE),
    "mounted without a known card")
  `SDMS_ASSERT_ALWAYS(a_reset_empty,
    $past(rst) |-> (!rsp.valid && !item_valid),
    "registers not empty after reset")

endmodule

@@ test/sdms_mount_checker.sv @@
// Checker for the card mount sequencer: tracks register writes and status
// reports, predicts each action beat and compares it field by field.
// Depends on sdms_pkg and the channel interfaces in sdms_if.sv.
module sdms_mount_checker import sdms_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  sdms_req_if         req,
  sdms_rsp_if         rsp,
  sdms_cfg_if         cfg,
  output int unsigned errors,
  output int unsigned outstanding,
  output int unsigned checked,
  output int unsigned mounts,
  output int unsigned give_ups,
  output int unsigned enable_errs,
  output int unsigned restarts
);

  typedef enum logic [3:0] {
    ST_NO_CARD,
    ST_SETTLE,
    ST_ENABLE,
    ST_GO_IDLE,
    ST_IF_COND,
    ST_OP_V1,
    ST_OP_V2,
    ST_OCR,
    ST_CSD,
    ST_SET_BLOCK,
    ST_MOUNTED,
    ST_GAVE_UP,
    ST_ENABLE_ERR
  } mount_step_t;

  // register copies
  logic [3:0]  max_restarts_cfg;
  logic [3:0]  idle_attempts_cfg;
  logic [9:0]  settle_cfg;
  logic [12:0] target_cfg;

  // sequencer state
  mount_step_t step_now;
  logic [3:0]  retries_left;
  logic [3:0]  idle_count;
  card_kind_t  kind_now;
  logic [31:0] blocks_now;
  logic [31:0] access_now;
  logic [12:0] card_blk_now;

  sdms_result_t due_actions[$];

  function automatic sdms_result_t shown(action_t act, mount_res_t res);
    sdms_result_t r;
    r.next_action      = act;
    r.wait_ms          = (act == ACT_WAIT) ? settle_cfg : 10'd0;
    r.mount_result     = res;
    r.card_type        = kind_now;
    r.block_count      = blocks_now;
    r.read_access_time = access_now;
    return r;
  endfunction

  // card proved unusable: back to the settle wait while restarts remain
  function automatic sdms_result_t retry_or_give_up();
    sdms_result_t r;
    if (retries_left != 4'd0) begin
      retries_left = retries_left - 4'd1;
      kind_now     = KIND_UNKNOWN;
      idle_count   = 4'd0;
      step_now     = ST_SETTLE;
      restarts++;
      r = shown(ACT_WAIT, RES_BUSY);
    end else begin
      step_now = ST_GAVE_UP;
      give_ups++;
      r = shown(ACT_NONE, RES_NOT_MOUNTED);
    end
    return r;
  endfunction

  function automatic sdms_result_t advance_mount(sdms_item_t rpt);
    sdms_result_t r;
    if (step_now != ST_NO_CARD && !rpt.card_present) begin
      step_now = ST_NO_CARD;
      kind_now = KIND_UNKNOWN;
      r = shown(ACT_NONE, RES_BUSY);
    end else begin
      case (step_now)
        ST_SETTLE: begin
          step_now = ST_ENABLE;
          r = shown(ACT_ENABLE, RES_BUSY);
        end
        ST_ENABLE: begin
          if (!rpt.action_ok) begin
            step_now = ST_ENABLE_ERR;
            enable_errs++;
            r = shown(ACT_NONE, RES_EN_ERR);
          end else begin
            idle_count = 4'd1;
            step_now   = ST_GO_IDLE;
            r = shown(ACT_IDLE, RES_BUSY);
          end
        end
        ST_GO_IDLE: begin
          if (rpt.action_ok) begin
            step_now = ST_IF_COND;
            r = shown(ACT_IFCOND, RES_BUSY);
          end else if (idle_count < idle_attempts_cfg) begin
            idle_count = idle_count + 4'd1;
            r = shown(ACT_IDLE, RES_BUSY);
          end else begin
            r = retry_or_give_up();
          end
        end
        ST_IF_COND: begin
          if (!rpt.action_ok) begin
            r = retry_or_give_up();
          end else if (rpt.response_flag) begin
            step_now = ST_OP_V2;
            r = shown(ACT_OP2, RES_BUSY);
          end else begin
            step_now = ST_OP_V1;
            r = shown(ACT_OP1, RES_BUSY);
          end
        end
        ST_OP_V1: begin
          if (!rpt.action_ok) begin
            // first v1 failure tries the MMC path, a second one counts the card as unusable
            if (kind_now == KIND_MMC) begin
              r = retry_or_give_up();
            end else begin
              kind_now   = KIND_MMC;
              idle_count = 4'd1;
              step_now   = ST_GO_IDLE;
              r = shown(ACT_IDLE, RES_BUSY);
            end
          end else if (!rpt.response_flag) begin
            r = shown(ACT_OP1, RES_BUSY);
          end else begin
            kind_now = KIND_SD1;
            step_now = ST_CSD;
            r = shown(ACT_CSD, RES_BUSY);
          end
        end
        ST_OP_V2: begin
          if (!rpt.action_ok) begin
            r = retry_or_give_up();
          end else if (!rpt.response_flag) begin
            r = shown(ACT_OP2, RES_BUSY);
          end else begin
            step_now = ST_OCR;
            r = shown(ACT_OCR, RES_BUSY);
          end
        end
        ST_OCR: begin
          if (!rpt.action_ok) begin
            r = retry_or_give_up();
          end else begin
            kind_now = rpt.response_flag ? KIND_SDHC : KIND_SD2;
            step_now = ST_CSD;
            r = shown(ACT_CSD, RES_BUSY);
          end
        end
        ST_CSD: begin
          if (!rpt.action_ok || rpt.csd_max_speed == '0 || rpt.csd_total_bytes == '0 ||
              rpt.csd_block_bytes == '0) begin
            r = retry_or_give_up();
          end else begin
            blocks_now   = 32'(rpt.csd_total_bytes >> 9);
            access_now   = rpt.csd_access_time;
            card_blk_now = rpt.csd_block_bytes;
            if (card_blk_now == target_cfg) begin
              step_now = ST_MOUNTED;
              mounts++;
              r = shown(ACT_NONE, RES_MOUNTED);
            end else begin
              step_now = ST_SET_BLOCK;
              r = shown(ACT_SETBLK, RES_BUSY);
            end
          end
        end
        ST_SET_BLOCK: begin
          if (rpt.action_ok) begin
            step_now = ST_MOUNTED;
            mounts++;
            r = shown(ACT_NONE, RES_MOUNTED);
          end else begin
            r = retry_or_give_up();
          end
        end
        ST_MOUNTED:    r = shown(ACT_NONE, RES_MOUNTED);
        ST_GAVE_UP:    r = shown(ACT_NONE, RES_NOT_MOUNTED);
        ST_ENABLE_ERR: r = shown(ACT_NONE, RES_EN_ERR);
        default: begin
          step_now = ST_NO_CARD;
          if (rpt.card_present) begin
            retries_left = max_restarts_cfg;
            idle_count   = 4'd0;
            kind_now     = KIND_UNKNOWN;
            blocks_now   = '0;
            access_now   = '0;
            card_blk_now = '0;
            step_now     = ST_SETTLE;
            r = shown(ACT_WAIT, RES_BUSY);
          end else begin
            r = shown(ACT_NONE, RES_BUSY);
          end
        end
      endcase
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    sdms_result_t want;
    sdms_item_t   rpt;
    if (rst) begin
      max_restarts_cfg  = MaxRestartsRst;
      idle_attempts_cfg = IdleAttemptsRst;
      settle_cfg        = PowerSettleRst;
      target_cfg        = TargetBlockRst;
      step_now          = ST_NO_CARD;
      retries_left      = MaxRestartsRst;
      idle_count        = '0;
      kind_now          = KIND_UNKNOWN;
      blocks_now        = '0;
      access_now        = '0;
      card_blk_now      = '0;
      due_actions.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          REG_MAX_RESTARTS:  max_restarts_cfg  = cfg.data[3:0];
          REG_IDLE_ATTEMPTS: idle_attempts_cfg = cfg.data[3:0];
          REG_POWER_SETTLE:  settle_cfg        = cfg.data[9:0];
          REG_TARGET_BLOCK:  target_cfg        = cfg.data;
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (due_actions.size() == 0) begin
          $error("action beat with nothing expected: next_action %0d", rsp.next_action);
          errors++;
        end else begin
          want = due_actions.pop_front();
          check_field("next_action", 32'(want.next_action), 32'(rsp.next_action));
          check_field("wait_ms", 32'(want.wait_ms), 32'(rsp.wait_ms));
          check_field("mount_result", 32'(want.mount_result), 32'(rsp.mount_result));
          check_field("card_type", 32'(want.card_type), 32'(rsp.card_type));
          check_field("block_count", want.block_count, rsp.block_count);
          check_field("read_access_time", want.read_access_time, rsp.read_access_time);
          checked++;
        end
      end
      if (req.valid && req.ready) begin
        rpt.card_present    = req.card_present;
        rpt.action_ok       = req.action_ok;
        rpt.response_flag   = req.response_flag;
        rpt.csd_max_speed   = req.csd_max_speed;
        rpt.csd_total_bytes = req.csd_total_bytes;
        rpt.csd_block_bytes = req.csd_block_bytes;
        rpt.csd_access_time = req.csd_access_time;
        due_actions.push_back(advance_mount(rpt));
      end
    end
    outstanding <= due_actions.size();
  end

endmodule

@@ test/sd_card_mount_sequencer_test.sv @@
// Top of the mount sequencer testbench: clock, reset, status report stimulus,
// register settings and result pacing. Checking lives in sdms_mount_checker.
// Depends on sdms_pkg, sdms_if.sv and the sequencer RTL.
module sd_card_mount_sequencer_test import sdms_pkg::*;;

  localparam int unsigned CycleLimit   = 600_000;
  localparam int unsigned DrainLimit   = 2_000;
  localparam int unsigned PhaseReports = 200;
  localparam int unsigned SettlePad    = 4;

  logic        clk;
  logic        rst;
  int unsigned cycle_count;
  int unsigned reports_sent;
  int unsigned settings_used;
  int unsigned burst_left;
  bit          steady_send;
  logic [12:0] cur_target;

  int unsigned errors, outstanding, checked, mounts, give_ups, enable_errs, restarts;

  sdms_req_if req_ch ();
  sdms_rsp_if rsp_ch ();
  sdms_cfg_if cfg_ch ();

  sd_card_mount_sequencer i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  sdms_mount_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg         (cfg_ch),
    .errors      (errors),
    .outstanding (outstanding),
    .checked     (checked),
    .mounts      (mounts),
    .give_ups    (give_ups),
    .enable_errs (enable_errs),
    .restarts    (restarts)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("sd_card_mount_sequencer_test NOT OK");
      $finish;
    end
  end

  // action sink: ready follows one of several patterns, switched now and then
  initial begin : sink_pacing
    int unsigned mode;
    int unsigned left;
    rsp_ch.ready <= 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(3);
        left = $urandom_range(20, 200);
      end
      left--;
      case (mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= ($urandom_range(9) < 7);
        2: rsp_ch.ready <= ($urandom_range(9) < 3);
        default: rsp_ch.ready <= ($urandom_range(11) == 0);
      endcase
    end
  end

  // status report with random CSD content
  function automatic sdms_item_t report(bit present, bit ok, bit flag);
    sdms_item_t it;
    it.card_present  = present;
    it.action_ok     = ok;
    it.response_flag = flag;
    case ($urandom_range(15))
      0:       it.csd_max_speed = '0;
      1:       it.csd_max_speed = '1;
      default: it.csd_max_speed = $urandom;
    endcase
    case ($urandom_range(15))
      0:       it.csd_total_bytes = '0;
      1:       it.csd_total_bytes = '1;
      2:       it.csd_total_bytes = 40'($urandom_range(1, 511));
      default: it.csd_total_bytes = {8'($urandom), 32'($urandom)} >> $urandom_range(0, 39);
    endcase
    case ($urandom_range(15))
      0:             it.csd_block_bytes = '0;
      1, 2, 3, 4, 5: it.csd_block_bytes = cur_target;
      6:             it.csd_block_bytes = 13'd4096;
      7:             it.csd_block_bytes = 13'd512;
      default:       it.csd_block_bytes = 13'($urandom_range(1, 4096));
    endcase
    it.csd_access_time = $urandom;
    return it;
  endfunction

  task automatic send_report(sdms_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady_send ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_ch.valid           <= 1'b1;
    req_ch.card_present    <= it.card_present;
    req_ch.action_ok       <= it.action_ok;
    req_ch.response_flag   <= it.response_flag;
    req_ch.csd_max_speed   <= it.csd_max_speed;
    req_ch.csd_total_bytes <= it.csd_total_bytes;
    req_ch.csd_block_bytes <= it.csd_block_bytes;
    req_ch.csd_access_time <= it.csd_access_time;
    do @(posedge clk); while (!req_ch.ready);
    reports_sent++;
  endtask

  // hold off until every expected action beat is back or DrainLimit runs out, then wait out SettlePad
  task automatic settle_down();
    int unsigned waited;
    req_ch.valid <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (outstanding != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (SettlePad) @(posedge clk);
    burst_left = 0;
  endtask

  // valid stays up across back-to-back writes; the caller drops it
  task automatic put_register(cfg_reg_t idx, logic [12:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic apply_settings(logic [3:0] restarts_max, logic [3:0] idle_max,
                                logic [9:0] settle_ms, logic [12:0] target);
    put_register(REG_MAX_RESTARTS, 13'(restarts_max));
    put_register(REG_IDLE_ATTEMPTS, 13'(idle_max));
    put_register(REG_POWER_SETTLE, 13'(settle_ms));
    put_register(REG_TARGET_BLOCK, target);
    cfg_ch.valid <= 1'b0;
    cur_target = target;
    settings_used++;
  endtask

  task automatic run_directed();
    sdms_item_t it;
    it = '0;                                   // no card, all fields low
    send_report(it);
    send_report(report(1'b1, 1'b1, 1'b0));     // insertion
    send_report(report(1'b1, 1'b0, 1'b1));     // settle outcome ignored
    send_report(report(1'b1, 1'b1, 1'b0));     // enable ok
    send_report(report(1'b1, 1'b0, 1'b0));     // go-idle retry
    send_report(report(1'b1, 1'b1, 1'b0));
    send_report(report(1'b1, 1'b1, 1'b1));     // v2 card
    send_report(report(1'b1, 1'b1, 1'b0));     // still polling
    send_report(report(1'b1, 1'b1, 1'b1));
    send_report(report(1'b1, 1'b1, 1'b1));     // OCR capacity bit: SDHC
    it = report(1'b1, 1'b1, 1'b1);
    it.csd_max_speed   = '1;
    it.csd_total_bytes = '1;
    it.csd_block_bytes = 13'd4096;
    it.csd_access_time = '1;
    send_report(it);                           // block length differs: set block
    send_report(report(1'b1, 1'b1, 1'b0));     // mounted
    it = '1;
    it.card_present    = 1'b0;
    it.csd_block_bytes = 13'd4096;
    send_report(it);                           // removal
    send_report(report(1'b1, 1'b1, 1'b0));
    send_report(report(1'b1, 1'b1, 1'b0));
    send_report(report(1'b1, 1'b0, 1'b0));     // enable error is final
    send_report(report(1'b1, 1'b1, 1'b1));
    send_report(report(1'b0, 1'b0, 1'b0));
    send_report(report(1'b1, 1'b1, 1'b0));
    send_report(report(1'b1, 1'b1, 1'b0));
    send_report(report(1'b1, 1'b1, 1'b0));
    send_report(report(1'b1, 1'b1, 1'b0));
    send_report(report(1'b1, 1'b1, 1'b0));     // v1 card
    send_report(report(1'b1, 1'b0, 1'b0));     // op-cond fails: MMC path
    send_report(report(1'b1, 1'b1, 1'b0));
    send_report(report(1'b1, 1'b1, 1'b0));
    send_report(report(1'b1, 1'b0, 1'b0));     // second v1 failure: restart
  endtask

  // one insertion with random outcomes, then removal; some sessions are noise
  task automatic run_card_session();
    int unsigned n;
    int unsigned fail_pct;
    int unsigned flag_pct;
    bit          noisy;
    n = $urandom_range(6, 60);
    case ($urandom_range(3))
      0:       fail_pct = 0;
      1:       fail_pct = 4;
      2:       fail_pct = 12;
      default: fail_pct = 35;
    endcase
    case ($urandom_range(2))
      0:       flag_pct = 25;
      1:       flag_pct = 50;
      default: flag_pct = 80;
    endcase
    noisy = ($urandom_range(9) == 0);
    repeat (n) begin
      send_report(report(noisy ? 1'($urandom_range(1)) : 1'b1,
                         $urandom_range(99) >= fail_pct, $urandom_range(99) < flag_pct));
    end
    repeat ($urandom_range(1, 2)) begin
      send_report(report(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1))));
    end
  endtask

  task automatic run_phase();
    int unsigned goal;
    goal = reports_sent + PhaseReports;
    steady_send = ($urandom_range(3) == 0);
    while (reports_sent < goal) run_card_session();
    settle_down();
  endtask

  initial begin : stimulus
    rst                    <= 1'b1;
    req_ch.valid           <= 1'b0;
    req_ch.card_present    <= 1'b0;
    req_ch.action_ok       <= 1'b0;
    req_ch.response_flag   <= 1'b0;
    req_ch.csd_max_speed   <= '0;
    req_ch.csd_total_bytes <= '0;
    req_ch.csd_block_bytes <= '0;
    req_ch.csd_access_time <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.index           <= REG_MAX_RESTARTS;
    cfg_ch.data            <= '0;
    cur_target    = TargetBlockRst;
    burst_left    = 0;
    steady_send   = 1'b0;
    settings_used = 1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    run_phase();

    apply_settings(4'd0, 4'd1, 10'd0, 13'd512);
    run_phase();
    apply_settings(4'd15, 4'd15, 10'd1023, 13'd4096);
    run_phase();
    // zero go-idle attempts acts as one; zero target never matches
    apply_settings(4'd1, 4'd0, 10'd1, 13'd0);
    run_phase();
    repeat (4) begin
      apply_settings(4'($urandom_range(0, 15)), 4'($urandom_range(1, 15)),
                     10'($urandom_range(0, 1023)), 13'($urandom_range(1, 4096)));
      run_phase();
    end

    if (outstanding != 0) $error("%0d action beats never arrived", outstanding);
    $display("covered %0d status reports under %0d register settings, %0d actions checked",
             reports_sent, settings_used, checked);
    $display("predicted %0d mounts, %0d give-ups, %0d enable errors, %0d restarts",
             mounts, give_ups, enable_errs, restarts);
    if (errors == 0 && outstanding == 0) begin
      $display("sd_card_mount_sequencer_test OK");
    end else begin
      $display("sd_card_mount_sequencer_test NOT OK");
    end
    $finish;
  end

endmodule
